FILE: design/nif_pkg.sv
// shared types, codes and constants of the nec ir frame decoder
package nif_pkg;

  localparam int TIMER_BITS = 16;
  localparam int IV_W       = 16;
  localparam int CFG_W      = 16;
  localparam int IDX_W      = 3;
  localparam int CNT_W      = 5;
  localparam int NBYTES     = 4;

  // keeps only the bits that the timer really counts
  localparam logic [IV_W-1:0] TMASK = (TIMER_BITS >= IV_W) ? {IV_W{1'b1}} :
                                      IV_W'((32'd1 << TIMER_BITS) - 32'd1);

  localparam logic [CNT_W-1:0] LAST_BIT = {CNT_W{1'b1}};

  // register indexes
  localparam logic [IDX_W-1:0] REG_START_MIN = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_MAX = 3'd1;
  localparam logic [IDX_W-1:0] REG_BIT_SPLIT = 3'd2;
  localparam logic [IDX_W-1:0] REG_ZERO_MIN  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ONE_MAX   = 3'd4;

  localparam logic [CFG_W-1:0] RST_START_MIN = 16'd8000;
  localparam logic [CFG_W-1:0] RST_START_MAX = 16'd14000;
  localparam logic [CFG_W-1:0] RST_BIT_SPLIT = 16'd1450;
  localparam logic [CFG_W-1:0] RST_ZERO_MIN  = 16'd700;
  localparam logic [CFG_W-1:0] RST_ONE_MAX   = 16'd3000;

  // interval classes
  typedef logic [1:0] cls_t;
  localparam cls_t CLS_NONE  = 2'd0;
  localparam cls_t CLS_START = 2'd1;
  localparam cls_t CLS_ONE   = 2'd2;
  localparam cls_t CLS_ZERO  = 2'd3;

  typedef struct packed {
    logic       push;
    cls_t       cls;
  } q_wr_t;

  typedef struct packed {
    logic       valid;
    cls_t       cls;
  } q_rd_t;

  typedef struct packed {
    logic       frame_done;
    logic       check_ok;
    logic [7:0] address_byte;
    logic [7:0] address_inv_byte;
    logic [7:0] command_byte;
    logic [7:0] last_key;
  } out_t;

endpackage

FILE: design/nif_front.sv
// front end: timing window registers and interval classification
module nif_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [nif_pkg::IDX_W-1:0]     cfg_index,
  input  logic [nif_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          q_full,
  input  logic [nif_pkg::IV_W-1:0]      edge_interval,
  output logic                          in_ready,
  output nif_pkg::q_wr_t                q_wr
);

  logic [nif_pkg::CFG_W-1:0] start_min;
  logic [nif_pkg::CFG_W-1:0] start_max;
  logic [nif_pkg::CFG_W-1:0] bit_split;
  logic [nif_pkg::CFG_W-1:0] zero_min;
  logic [nif_pkg::CFG_W-1:0] one_max;
  logic [nif_pkg::IV_W-1:0]  t;
  logic                      is_start;
  logic                      is_one;
  logic                      is_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_min <= nif_pkg::RST_START_MIN;
      start_max <= nif_pkg::RST_START_MAX;
      bit_split <= nif_pkg::RST_BIT_SPLIT;
      zero_min  <= nif_pkg::RST_ZERO_MIN;
      one_max   <= nif_pkg::RST_ONE_MAX;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nif_pkg::REG_START_MIN: start_min <= cfg_data;
        nif_pkg::REG_START_MAX: start_max <= cfg_data;
        nif_pkg::REG_BIT_SPLIT: bit_split <= cfg_data;
        nif_pkg::REG_ZERO_MIN:  zero_min  <= cfg_data;
        nif_pkg::REG_ONE_MAX:   one_max   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign t        = edge_interval & nif_pkg::TMASK;
  assign is_start = (t > start_min) && (t < start_max);
  assign is_one   = (t > bit_split) && (t < one_max);
  assign is_zero  = (t > zero_min) && (t < bit_split);

  assign in_ready = !q_full;

  always_comb begin
    q_wr.push = in_valid && !q_full;
    // leader test wins over the bit windows
    priority if (is_start) q_wr.cls = nif_pkg::CLS_START;
    else if (is_one)       q_wr.cls = nif_pkg::CLS_ONE;
    else if (is_zero)      q_wr.cls = nif_pkg::CLS_ZERO;
    else                   q_wr.cls = nif_pkg::CLS_NONE;
  end

endmodule

FILE: design/nif_queue.sv
// two-entry queue of interval classes between front and back
module nif_queue (
  input  logic           clk,
  input  logic           rst,
  input  nif_pkg::q_wr_t q_wr,
  input  logic           pop,
  output logic           full,
  output nif_pkg::q_rd_t q_rd
);

  nif_pkg::cls_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_pop;

  assign full   = (count == 2'd2);
  assign do_pop = pop && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem[wr_ptr] <= q_wr.cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_wr.push) wr_ptr <= !wr_ptr;
      if (do_pop)    rd_ptr <= !rd_ptr;
      count <= count + 2'(q_wr.push) - 2'(do_pop);
    end
  end

  assign q_rd.valid = (count != 2'd0);
  assign q_rd.cls   = mem[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !q_wr.push)
    else $error("queue written while full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 && !q_wr.push) |=> count == 2'd0)
    else $error("empty queue changed without a push");

endmodule

FILE: design/nif_back.sv
// back end: frame assembly, check and output register
module nif_back (
  input  logic           clk,
  input  logic           rst,
  input  nif_pkg::q_rd_t q_rd,
  input  logic           out_ready,
  output logic           pop,
  output logic           out_valid,
  output nif_pkg::out_t  out
);

  logic                      armed;
  logic                      armed_next;
  logic [nif_pkg::CNT_W-1:0] bit_count;
  logic [nif_pkg::CNT_W-1:0] bit_count_next;
  logic [7:0]                frame_bytes [nif_pkg::NBYTES];
  logic [7:0]                frame_bytes_next [nif_pkg::NBYTES];
  logic [7:0]                key_reg;
  logic [7:0]                key_reg_next;
  logic                      done_next;
  logic                      ok_next;
  logic                      shift;
  logic                      bit_val;
  logic [1:0]                byte_sel;

  assign pop = q_rd.valid && (!out_valid || out_ready);

  always_comb begin
    armed_next     = armed;
    bit_count_next = bit_count;
    key_reg_next   = key_reg;
    done_next      = 1'b0;
    ok_next        = 1'b0;
    shift          = 1'b0;
    bit_val        = 1'b0;
    byte_sel       = bit_count[nif_pkg::CNT_W-1:3];
    for (int i = 0; i < nif_pkg::NBYTES; i++) begin
      frame_bytes_next[i] = frame_bytes[i];
    end
    unique case (q_rd.cls)
      nif_pkg::CLS_START: begin
        armed_next     = 1'b1;
        bit_count_next = '0;
      end
      nif_pkg::CLS_ONE: begin
        shift   = armed;
        bit_val = 1'b1;
      end
      nif_pkg::CLS_ZERO: begin
        shift   = armed;
        bit_val = 1'b0;
      end
      default: ;
    endcase
    if (shift) begin
      // lsb first: new bit enters at the top and moves down
      for (int i = 0; i < nif_pkg::NBYTES; i++) begin
        if (byte_sel == 2'(i)) begin
          frame_bytes_next[i] = {bit_val, frame_bytes[i][7:1]};
        end
      end
      bit_count_next = bit_count + 1'b1;
      if (bit_count == nif_pkg::LAST_BIT) begin
        armed_next = 1'b0;
        done_next  = 1'b1;
        if (frame_bytes_next[2] == ~frame_bytes_next[3]) begin
          ok_next      = 1'b1;
          key_reg_next = frame_bytes_next[2];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      bit_count <= '0;
      key_reg   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < nif_pkg::NBYTES; i++) begin
        frame_bytes[i] <= '0;
      end
    end else begin
      if (pop) begin
        armed     <= armed_next;
        bit_count <= bit_count_next;
        key_reg   <= key_reg_next;
        for (int i = 0; i < nif_pkg::NBYTES; i++) begin
          frame_bytes[i] <= frame_bytes_next[i];
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out.frame_done       <= done_next;
      out.check_ok         <= ok_next;
      out.address_byte     <= frame_bytes_next[0];
      out.address_inv_byte <= frame_bytes_next[1];
      out.command_byte     <= frame_bytes_next[2];
      out.last_key         <= key_reg_next;
    end
  end

  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    !armed |-> bit_count == '0)
    else $error("bit count nonzero while disarmed");

  a_done_disarms: assert property (@(posedge clk) disable iff (rst)
    (pop && done_next) |=> !armed)
    else $error("still armed after a completed frame");

  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out.check_ok) |-> out.frame_done)
    else $error("check passed without a completed frame");

  a_ok_latches_key: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out.check_ok) |-> out.last_key == out.command_byte)
    else $error("key not taken from a checked frame");

endmodule

FILE: design/nec_ir_frame_decoder_unit.sv
// top level of the nec ir frame decoder
//
//   channel  dir  handshake          payload
//   s_axis   in   s_tvalid/s_tready  s_tdata = edge_interval
//   m_axis   out  m_tvalid/m_tready  m_tdata = bytes + key, m_tlast = frame_done,
//                                    m_tuser = check_ok
//   cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// one beat in per cycle and one beat out per cycle when m_tready stays high;
// each edge interval passes from input beat to output beat through the queue and then
// the output register (classification into the queue, then frame update into it).
// synchronous active-high reset clears the windows to their defaults, the
// frame state and the queue. a stalled output holds its beat while the two-entry
// queue absorbs input, and s_tready drops only when that queue is full.
module nec_ir_frame_decoder_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [15:0]               s_tdata,    // [15:0] edge_interval
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [31:0]               m_tdata,    // [7:0] address_byte, [15:8] address_inv_byte,
                                                // [23:16] command_byte, [31:24] last_key
  output logic                      m_tlast,    // frame_done
  output logic                      m_tuser,    // check_ok
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [nif_pkg::IDX_W-1:0] cfg_index,
  input  logic [nif_pkg::CFG_W-1:0] cfg_data
);

  nif_pkg::q_wr_t q_wr;
  nif_pkg::q_rd_t q_rd;
  nif_pkg::out_t  out;
  logic           q_full;
  logic           pop;

  assign cfg_ready = 1'b1;

  nif_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (s_tvalid),
    .q_full        (q_full),
    .edge_interval (s_tdata),
    .in_ready      (s_tready),
    .q_wr          (q_wr)
  );

  nif_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .pop  (pop),
    .full (q_full),
    .q_rd (q_rd)
  );

  nif_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rd      (q_rd),
    .out_ready (m_tready),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out       (out)
  );

  assign m_tdata = {out.last_key, out.command_byte, out.address_inv_byte, out.address_byte};
  assign m_tlast = out.frame_done;
  assign m_tuser = out.check_ok;

endmodule

FILE: bench/tb.sv
// testbench of the nec ir frame decoder: directed table, random frames, predicted beats
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [15:0]   iv;
    logic          typed;
    nif_pkg::out_t beat;
  } dir_row_t;

  localparam nif_pkg::out_t IDLE_BEAT   = '0;
  localparam int            N_DIR       = 20;
  localparam int            N_PHASES    = 8;
  localparam int            PHASE_ITEMS = 160;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [15:0]               s_tdata   = '0;
  logic                      m_tvalid;
  logic                      m_tready  = 1'b1;
  logic [31:0]               m_tdata;
  logic                      m_tlast;
  logic                      m_tuser;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [nif_pkg::IDX_W-1:0] cfg_index = '0;
  logic [nif_pkg::CFG_W-1:0] cfg_data  = '0;

  // decoder copy: windows, frame state and key
  logic [15:0] win_start_min = nif_pkg::RST_START_MIN;
  logic [15:0] win_start_max = nif_pkg::RST_START_MAX;
  logic [15:0] win_split     = nif_pkg::RST_BIT_SPLIT;
  logic [15:0] win_zero_min  = nif_pkg::RST_ZERO_MIN;
  logic [15:0] win_one_max   = nif_pkg::RST_ONE_MAX;
  logic        rx_armed      = 1'b0;
  int          rx_bits       = 0;
  logic [7:0]  rx_bytes [4]  = '{8'h00, 8'h00, 8'h00, 8'h00};
  logic [7:0]  rx_key        = 8'h00;

  nif_pkg::out_t decoded_q [$];
  nif_pkg::out_t want_beat;
  nif_pkg::out_t seen_beat;
  int            errors         = 0;
  int            items_sent     = 0;
  int            send_idle_pct  = 0;
  int            sink_stall_pct = 0;

  // only the first rows can be read off by eye; the rest go through the decoder copy
  dir_row_t dir_rows [N_DIR] = '{
    {16'd0,     1'b1, IDLE_BEAT},  // below every window
    {16'hffff,  1'b1, IDLE_BEAT},
    {16'd2000,  1'b1, IDLE_BEAT},  // one bit while disarmed
    {16'd1000,  1'b1, IDLE_BEAT},  // zero bit while disarmed
    {16'd8000,  1'b1, IDLE_BEAT},  // leader bounds are exclusive
    {16'd14000, 1'b1, IDLE_BEAT},
    {16'd8001,  1'b1, IDLE_BEAT},  // arms
    {16'd1450,  1'b1, IDLE_BEAT},  // split value belongs to neither bit window
    {16'd700,   1'b1, IDLE_BEAT},
    {16'd3000,  1'b1, IDLE_BEAT},
    {16'd2999,  1'b0, IDLE_BEAT},
    {16'd701,   1'b0, IDLE_BEAT},
    {16'd1451,  1'b0, IDLE_BEAT},
    {16'd1449,  1'b0, IDLE_BEAT},
    {16'd13999, 1'b0, IDLE_BEAT},  // leader while armed keeps the bytes
    {16'd2000,  1'b0, IDLE_BEAT},
    {16'd699,   1'b0, IDLE_BEAT},
    {16'd3001,  1'b0, IDLE_BEAT},
    {16'hffff,  1'b0, IDLE_BEAT},
    {16'd1,     1'b0, IDLE_BEAT}
  };

  nec_ir_frame_decoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic nif_pkg::out_t decode_interval(input logic [15:0] iv);
    nif_pkg::out_t r;
    logic [15:0]   t;
    logic [1:0]    slot;
    r = '0;
    t = iv & nif_pkg::TMASK;
    if (t > win_start_min && t < win_start_max) begin
      rx_bits  = 0;
      rx_armed = 1'b1;
    end else if (rx_armed) begin
      if ((t > win_split && t < win_one_max) || (t > win_zero_min && t < win_split)) begin
        // lsb first: new bit enters at the top and moves down
        slot = rx_bits[4:3];
        rx_bytes[slot] = {t > win_split, rx_bytes[slot][7:1]};
        rx_bits++;
      end
      if (rx_bits >= 32) begin
        rx_bits      = 0;
        rx_armed     = 1'b0;
        r.frame_done = 1'b1;
        if (rx_bytes[2] == 8'(~rx_bytes[3])) begin
          r.check_ok = 1'b1;
          rx_key     = rx_bytes[2];
        end
      end
    end
    r.address_byte     = rx_bytes[0];
    r.address_inv_byte = rx_bytes[1];
    r.command_byte     = rx_bytes[2];
    r.last_key         = rx_key;
    return r;
  endfunction

  function automatic logic [15:0] pick_between(input int lo, input int hi);
    if (hi - lo >= 2) return 16'($urandom_range(hi - 1, lo + 1));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] boundary_value();
    case ($urandom_range(4))
      0:       return win_start_min;
      1:       return win_start_max;
      2:       return win_split;
      3:       return win_zero_min;
      default: return win_one_max;
    endcase
  endfunction

  task automatic send_iv(input logic [15:0] iv, input logic typed,
                         input nif_pkg::out_t typed_beat);
    nif_pkg::out_t beat;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = iv;
    do @(posedge clk); while (!s_tready);
    beat = decode_interval(iv);
    if (typed) beat = typed_beat;
    decoded_q.push_back(beat);
    items_sent++;
  endtask

  task automatic drain_decoder();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [nif_pkg::IDX_W-1:0] idx,
                           input logic [nif_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      nif_pkg::REG_START_MIN: win_start_min = val;
      nif_pkg::REG_START_MAX: win_start_max = val;
      nif_pkg::REG_BIT_SPLIT: win_split     = val;
      nif_pkg::REG_ZERO_MIN:  win_zero_min  = val;
      nif_pkg::REG_ONE_MAX:   win_one_max   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_windows(input int smin, input int smax, input int split,
                             input int zmin, input int omax);
    write_reg(nif_pkg::REG_START_MIN, 16'(smin));
    write_reg(nif_pkg::REG_START_MAX, 16'(smax));
    write_reg(nif_pkg::REG_BIT_SPLIT, 16'(split));
    write_reg(nif_pkg::REG_ZERO_MIN,  16'(zmin));
    write_reg(nif_pkg::REG_ONE_MAX,   16'(omax));
  endtask

  // leader plus random payload; some frames stop early, some carry stray edges
  task automatic send_frame();
    logic [7:0] fb [4];
    int         nbits;
    int         k;
    for (k = 0; k < 4; k++) fb[k] = 8'($urandom);
    if ($urandom_range(1)) fb[3] = ~fb[2];
    nbits = ($urandom_range(9) == 0) ? $urandom_range(31) : 32;
    send_iv(pick_between(win_start_min, win_start_max), 1'b0, IDLE_BEAT);
    for (k = 0; k < nbits; k++) begin
      if ($urandom_range(24) == 0) send_iv(boundary_value(), 1'b0, IDLE_BEAT);
      if (fb[k / 8][k % 8])
        send_iv(pick_between(win_split, win_one_max), 1'b0, IDLE_BEAT);
      else
        send_iv(pick_between(win_zero_min, win_split), 1'b0, IDLE_BEAT);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_beat = {m_tlast, m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                   m_tdata[31:24]};
      if (decoded_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("output beat with nothing pending: %h", seen_beat);
      end else begin
        want_beat = decoded_q.pop_front();
        if (want_beat.frame_done       !== seen_beat.frame_done       ||
            want_beat.check_ok         !== seen_beat.check_ok         ||
            want_beat.address_byte     !== seen_beat.address_byte     ||
            want_beat.address_inv_byte !== seen_beat.address_inv_byte ||
            want_beat.command_byte     !== seen_beat.command_byte     ||
            want_beat.last_key         !== seen_beat.last_key) begin
          errors++;
          if (errors <= 10)
            $display({"beat differs (expected/actual): done %b/%b ok %b/%b",
                      " addr %h/%h inv %h/%h cmd %h/%h key %h/%h"},
                     want_beat.frame_done, seen_beat.frame_done,
                     want_beat.check_ok, seen_beat.check_ok,
                     want_beat.address_byte, seen_beat.address_byte,
                     want_beat.address_inv_byte, seen_beat.address_inv_byte,
                     want_beat.command_byte, seen_beat.command_byte,
                     want_beat.last_key, seen_beat.last_key);
        end
      end
    end
  end

  initial begin
    int ph;
    int i;
    int target;
    int pick;
    int zmin;
    int split;
    int omax;
    int smin;
    bit held;
    held = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (i = 0; i < N_DIR; i++)
      send_iv(dir_rows[i].iv, dir_rows[i].typed, dir_rows[i].beat);
    for (ph = 0; ph < N_PHASES; ph++) begin
      drain_decoder();
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          sink_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 62;
          sink_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          sink_stall_pct = 62;
        end
        default: begin
          send_idle_pct  = 23;
          sink_stall_pct = 23;
        end
      endcase
      case (ph)
        1, 3, 6: begin
          zmin  = $urandom_range(1500);
          split = zmin + $urandom_range(600, 2);
          omax  = split + $urandom_range(1500, 2);
          smin  = omax + $urandom_range(300);
          set_windows(smin, smin + $urandom_range(6000, 2), split, zmin, omax);
        end
        2: set_windows(4, 65535, 2, 0, 4);              // narrowest bit windows at the bottom
        4: set_windows(0, 2, 65533, 65530, 65535);      // bit windows at the top of the range
        5: begin
          set_windows(65535, 0, 0, 65535, 0);           // start and zero windows inverted, one window empty
          write_reg(nif_pkg::IDX_W'(5), 16'($urandom));
          write_reg(nif_pkg::IDX_W'(6), 16'($urandom));
          write_reg(nif_pkg::IDX_W'(7), 16'($urandom));
        end
        7: set_windows(nif_pkg::RST_START_MIN, nif_pkg::RST_START_MAX,
                       nif_pkg::RST_BIT_SPLIT, nif_pkg::RST_ZERO_MIN,
                       nif_pkg::RST_ONE_MAX);
        default: ;
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        // hold the source once until the decoder has emptied out
        if (ph == 3 && !held && items_sent >= target - PHASE_ITEMS / 2) begin
          drain_decoder();
          held = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 75)
          send_frame();
        else if (pick < 90)
          repeat ($urandom_range(4, 1)) send_iv(16'($urandom), 1'b0, IDLE_BEAT);
        else
          send_iv(boundary_value(), 1'b0, IDLE_BEAT);
      end
    end
    drain_decoder();
    repeat (4) @(posedge clk);
    if (errors == 0 && decoded_q.size() == 0)
      $display("nec_ir_frame_decoder_unit: match");
    else
      $display("nec_ir_frame_decoder_unit: mismatch");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("nec_ir_frame_decoder_unit: mismatch");
    $finish;
  end

endmodule

FILE: filelist.f
design/nif_pkg.sv
design/nif_front.sv
design/nif_queue.sv
design/nif_back.sv
design/nec_ir_frame_decoder_unit.sv
bench/tb.sv
